// ----- hdl/redr_pkg.sv -----
`default_nettype none

package redr_pkg;

    localparam int MODE_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int DIST_W  = 7;
    localparam int RATIO_W = 17;

    // quotient bits of the ratio: one integer bit plus sixteen fraction bits
    localparam int QUO_STEPS = RATIO_W;
    localparam int DIVCNT_W  = $clog2(QUO_STEPS);

    localparam logic [MODE_W-1:0] MODE_FIRST   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPARE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic append_first;
        logic append_second;
        logic cmp_start;
        logic init_write;
        logic col_advance;
        logic col_start;
        logic cell_step;
        logic div_load;
        logic div_step;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic row_last;
        logic m_zero;
        logic n_zero;
        logic col_last;
        logic div_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- hdl/restricted_edit_distance_ratio.sv -----
`default_nettype none

// Restricted edit distance (optimal string alignment) with a Q1.16 similarity
// ratio. Each input beat either appends s_char_code to the first string
// (mode 0) or the second (mode 1), or starts a compare (mode 2); mode 3 is
// accepted and ignored. Appends are accepted even while a previous result
// waits on the output. A compare of lengths m and n runs the single cell
// unit, which computes one dynamic-program cell per cycle within a column
// while walking the columns down through three rotating column memories,
// and then a restoring divider for the ratio. The result beat carries the
// distance (masked to 7 bits), floor(65536*(L-d)/L) with L the longer length
// (0 when both strings are empty), and a flag for bytes dropped past MAX_LEN
// since the last compare. Both strings and the flag clear when the result is
// loaded. No clearing pass after reset.

module restricted_edit_distance_ratio #(
    parameter int MAX_LEN = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input channel
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [redr_pkg::MODE_W-1:0]      s_mode,
    input  wire  [redr_pkg::CHAR_W-1:0]      s_char_code,
    // result channel
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [redr_pkg::DIST_W-1:0]      m_distance,
    output logic [redr_pkg::RATIO_W-1:0]     m_ratio_q16,
    output logic                             m_overflow
);

    redr_pkg::cmd_t  cmd;
    redr_pkg::stat_t stat;

    // sequencing and both handshakes
    redr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // string stores, column memories, cell unit, divider, result register
    redr_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .char_code (s_char_code),
        .stat      (stat),
        .distance  (m_distance),
        .ratio_q16 (m_ratio_q16),
        .overflow  (m_overflow)
    );

endmodule

`default_nettype wire

// ----- hdl/redr_ctrl.sv -----
`default_nettype none

module redr_ctrl (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [redr_pkg::MODE_W-1:0]      s_mode,
    output logic                             m_valid,
    input  wire                              m_ready,
    input  redr_pkg::stat_t                  stat,
    output redr_pkg::cmd_t                   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_INIT = 7'b0000010,
        ST_COL  = 7'b0000100,
        ST_CELL = 7'b0001000,
        ST_PREP = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   in_beat;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    case (s_mode)
                        redr_pkg::MODE_FIRST:   cmd.append_first  = 1'b1;
                        redr_pkg::MODE_SECOND:  cmd.append_second = 1'b1;
                        redr_pkg::MODE_COMPARE: begin
                            cmd.cmp_start = 1'b1;
                            state_next    = ST_INIT;
                        end
                        default: ;  // unused code: beat is dropped
                    endcase
                end
            end
            ST_INIT: begin
                cmd.init_write = 1'b1;
                if (stat.row_last) begin
                    if (stat.n_zero) begin
                        state_next = ST_PREP;
                    end else begin
                        cmd.col_advance = 1'b1;
                        state_next      = ST_COL;
                    end
                end
            end
            ST_COL: begin
                cmd.col_start = 1'b1;
                if (stat.m_zero) begin
                    if (stat.col_last) begin
                        state_next = ST_PREP;
                    end else begin
                        cmd.col_advance = 1'b1;
                    end
                end else begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                cmd.cell_step = 1'b1;
                if (stat.row_last) begin
                    if (stat.col_last) begin
                        state_next = ST_PREP;
                    end else begin
                        cmd.col_advance = 1'b1;
                        state_next      = ST_COL;
                    end
                end
            end
            ST_PREP: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.finish   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/redr_datapath.sv -----
`default_nettype none

module redr_datapath #(
    parameter int MAX_LEN = 64
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  redr_pkg::cmd_t                    cmd,
    input  wire  [redr_pkg::CHAR_W-1:0]       char_code,
    output redr_pkg::stat_t                   stat,
    output logic [redr_pkg::DIST_W-1:0]       distance,
    output logic [redr_pkg::RATIO_W-1:0]      ratio_q16,
    output logic                              overflow
);

    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int COL_DEPTH = MAX_LEN + 1;
    localparam int NBANK     = 3;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

    // string stores and lengths
    logic [redr_pkg::CHAR_W-1:0] first_mem  [MAX_LEN];
    logic [redr_pkg::CHAR_W-1:0] second_mem [MAX_LEN];
    logic [LEN_W-1:0] first_len_reg, second_len_reg;
    logic             dropped_reg;
    logic             first_full, second_full;

    // sweep counters
    logic [LEN_W-1:0] i_reg, j_reg;
    logic [1:0]       role_cur_reg;
    logic [1:0]       role_ob, role_tb;

    // cell operands
    logic [redr_pkg::CHAR_W-1:0] a_data_reg, a_prev_reg, b1_reg, b2_reg;
    logic [LEN_W-1:0] cur_prev_reg, ob_prev_reg, dist_reg;
    logic [LEN_W-1:0] bank_rdata [NBANK];
    logic [LEN_W-1:0] ob_data, tb_data;

    logic             rd_en;
    logic [LEN_W-1:0] ob_addr, tb_addr, a_addr, j_m1, j_m2;
    logic             bank_we;
    logic [LEN_W-1:0] bank_waddr, bank_wdata;

    logic             cost;
    logic [LEN_W:0]   del_c, ins_c, sub_c, swp_c, best3, best_w;
    logic             swap_ok;
    logic [LEN_W-1:0] best;

    // divider
    logic [LEN_W-1:0]                   longest;
    logic [LEN_W:0]                     rem_reg, rem_diff;
    logic [LEN_W-1:0]                   rem_keep;
    logic                               rem_ge;
    logic [redr_pkg::RATIO_W-1:0]       quo_reg;
    logic [redr_pkg::DIVCNT_W-1:0]      divcnt_reg;

    logic [redr_pkg::DIST_W-1:0]        distance_reg;
    logic [redr_pkg::RATIO_W-1:0]       ratio_reg;
    logic                               overflow_reg;

    assign first_full  = (first_len_reg == LEN_MAX);
    assign second_full = (second_len_reg == LEN_MAX);
    assign longest     = (first_len_reg > second_len_reg) ? first_len_reg : second_len_reg;

    // ---- status ----
    assign stat.row_last = (i_reg == first_len_reg);
    assign stat.m_zero   = (first_len_reg == '0);
    assign stat.n_zero   = (second_len_reg == '0);
    assign stat.col_last = (j_reg == second_len_reg);
    assign stat.div_last = (divcnt_reg == redr_pkg::DIVCNT_W'(redr_pkg::QUO_STEPS - 1));

    // ---- bank roles: current, one column back, two columns back ----
    always_comb begin
        case (role_cur_reg)
            2'd0:    begin role_ob = 2'd2; role_tb = 2'd1; end
            2'd1:    begin role_ob = 2'd0; role_tb = 2'd2; end
            2'd2:    begin role_ob = 2'd1; role_tb = 2'd0; end
            default: begin role_ob = 2'd0; role_tb = 2'd0; end
        endcase
    end

    // reads for the next cell; a column start primes cell one
    assign rd_en   = cmd.col_start || (cmd.cell_step && !stat.row_last);
    assign ob_addr = cmd.col_start ? LEN_ONE : i_reg + LEN_ONE;
    assign tb_addr = i_reg - LEN_ONE;
    assign a_addr  = cmd.col_start ? '0 : i_reg;
    assign j_m1    = j_reg - LEN_ONE;
    assign j_m2    = j_reg - LEN_W'(2);

    assign bank_we = cmd.init_write || cmd.col_start || cmd.cell_step;

    always_comb begin
        bank_waddr = i_reg;
        bank_wdata = i_reg;
        if (cmd.col_start) begin
            bank_waddr = '0;
            bank_wdata = j_reg;
        end else if (cmd.cell_step) begin
            bank_wdata = best;
        end
    end

    for (genvar k = 0; k < NBANK; k++) begin : g_bank
        logic [LEN_W-1:0] col_mem [COL_DEPTH];
        logic [LEN_W-1:0] rd_reg;
        always_ff @(posedge aclk) begin
            if (bank_we && role_cur_reg == 2'(k)) begin
                col_mem[bank_waddr] <= bank_wdata;
            end
            if (rd_en) begin
                rd_reg <= col_mem[(role_ob == 2'(k)) ? ob_addr : tb_addr];
            end
        end
        assign bank_rdata[k] = rd_reg;
    end

    assign ob_data = bank_rdata[role_ob];
    assign tb_data = bank_rdata[role_tb];

    // ---- string stores ----
    always_ff @(posedge aclk) begin
        if (cmd.append_first && !first_full) begin
            first_mem[first_len_reg[IDX_W-1:0]] <= char_code;
        end
        if (rd_en) begin
            a_data_reg <= first_mem[a_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.append_second && !second_full) begin
            second_mem[second_len_reg[IDX_W-1:0]] <= char_code;
        end
        if (cmd.col_start) begin
            b1_reg <= second_mem[j_m1[IDX_W-1:0]];
            b2_reg <= second_mem[j_m2[IDX_W-1:0]];
        end
    end

    // ---- one cell ----
    always_comb begin
        cost    = (a_data_reg != b1_reg);
        del_c   = {1'b0, cur_prev_reg} + 1'b1;
        ins_c   = {1'b0, ob_data} + 1'b1;
        sub_c   = {1'b0, ob_prev_reg} + {{LEN_W{1'b0}}, cost};
        swp_c   = {1'b0, tb_data} + {{LEN_W{1'b0}}, cost};
        best3   = (del_c < ins_c) ? del_c : ins_c;
        best3   = (sub_c < best3) ? sub_c : best3;
        swap_ok = (i_reg > LEN_ONE) && (j_reg > LEN_ONE)
                  && (a_data_reg == b2_reg) && (a_prev_reg == b1_reg);
        best_w  = (swap_ok && (swp_c < best3)) ? swp_c : best3;
        best    = best_w[LEN_W-1:0];
    end

    // ---- counters and cell registers ----
    always_ff @(posedge aclk) begin
        if (cmd.cmp_start) begin
            i_reg    <= '0;
            j_reg    <= '0;
            dist_reg <= first_len_reg;
        end
        if (cmd.init_write) begin
            i_reg <= i_reg + LEN_ONE;
        end
        if (cmd.col_advance) begin
            j_reg <= j_reg + LEN_ONE;
        end
        if (cmd.col_start) begin
            i_reg        <= LEN_ONE;
            cur_prev_reg <= j_reg;
            ob_prev_reg  <= j_m1;
            dist_reg     <= j_reg;
        end
        if (cmd.cell_step) begin
            i_reg        <= i_reg + LEN_ONE;
            cur_prev_reg <= best;
            ob_prev_reg  <= ob_data;
            a_prev_reg   <= a_data_reg;
            dist_reg     <= best;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            role_cur_reg <= 2'd0;
        end else if (cmd.col_advance) begin
            role_cur_reg <= (role_cur_reg == 2'd2) ? 2'd0 : role_cur_reg + 2'd1;
        end
    end

    // ---- restoring divider, one quotient bit a cycle ----
    always_comb begin
        rem_diff = rem_reg - {1'b0, longest};
        rem_ge   = (rem_reg >= {1'b0, longest});
        rem_keep = rem_ge ? rem_diff[LEN_W-1:0] : rem_reg[LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            rem_reg    <= {1'b0, longest - dist_reg};
            quo_reg    <= '0;
            divcnt_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg    <= {rem_keep, 1'b0};
            quo_reg    <= {quo_reg[redr_pkg::RATIO_W-2:0], rem_ge};
            divcnt_reg <= divcnt_reg + 1'b1;
        end
    end

    // ---- lengths and drop flag ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
        end else if (cmd.finish) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            dropped_reg    <= 1'b0;
        end else begin
            if (cmd.append_first) begin
                if (first_full) dropped_reg <= 1'b1;
                else            first_len_reg <= first_len_reg + LEN_ONE;
            end
            if (cmd.append_second) begin
                if (second_full) dropped_reg <= 1'b1;
                else             second_len_reg <= second_len_reg + LEN_ONE;
            end
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            distance_reg <= redr_pkg::DIST_W'(dist_reg);
            ratio_reg    <= (longest == '0) ? '0 : quo_reg;
            overflow_reg <= dropped_reg;
        end
    end

    assign distance  = distance_reg;
    assign ratio_q16 = ratio_reg;
    assign overflow  = overflow_reg;

endmodule

`default_nettype wire
